[src/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg
// Shared types and constants of the serial packet receiver.
// ----------------------------------------------------------------------------
package spr_pkg;

  // packet ids, compared after clearing bit 0
  localparam logic [7:0] ID_POLL  = 8'h30;
  localparam logic [7:0] ID_BAUD  = 8'h32;
  localparam logic [7:0] ID_DATA  = 8'h34;
  localparam logic [7:0] ID_FIN   = 8'h38;
  localparam logic [7:0] ID_MASK  = 8'hFE;
  localparam logic [7:0] PID_INIT = 8'hFF;

  localparam logic [7:0] BYTE_ACK = 8'h41;
  localparam logic [7:0] BYTE_NAK = ~BYTE_ACK;

  // input kinds
  localparam logic KIND_BYTE    = 1'b0;
  localparam logic KIND_TIMEOUT = 1'b1;

  // result kinds
  localparam logic [2:0] K_TX      = 3'd0;
  localparam logic [2:0] K_TENT    = 3'd1;
  localparam logic [2:0] K_COMMIT  = 3'd2;
  localparam logic [2:0] K_DISCARD = 3'd3;
  localparam logic [2:0] K_SWITCH  = 3'd4;
  localparam logic [2:0] K_DONE    = 3'd5;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
  } res_t;

  // all results caused by one input beat, res[0] goes out first
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     res;
  } bundle_t;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_LOAD = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

endpackage

[src/spr_core.sv]
// ----------------------------------------------------------------------------
// spr_core
// Input register and packet state; turns one input beat into a result bundle.
// ----------------------------------------------------------------------------
module spr_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  logic             kind,
  input  logic [7:0]       rx_byte,
  input  logic [1:0]       baud_code,
  input  logic             free,
  output logic             take,
  output spr_pkg::bundle_t bnd
);
  import spr_pkg::*;

  typedef struct packed {
    bundle_t bnd;
    logic    set_prev;
    logic    to_done;
  } fin_t;

  // acts on a completely received packet
  function automatic fin_t finish(input logic [7:0] pid, input logic [15:0] len,
                                  input logic [7:0] sum, input logic [1:0] code);
    fin_t f;
    f = '0;
    case (pid & ID_MASK)
      ID_POLL: begin
        f.set_prev   = 1'b1;
        f.bnd.res[0] = '{K_TX, BYTE_ACK};
        f.bnd.cnt    = 2'd1;
      end
      ID_BAUD: begin
        f.set_prev   = 1'b1;
        f.bnd.res[0] = '{K_TX, {6'd0, code}};
        if (code != 2'd0) begin
          f.bnd.res[1] = '{K_SWITCH, {6'd0, code}};
          f.bnd.res[2] = '{K_TX, BYTE_ACK};
          f.bnd.cnt    = 2'd3;
        end else begin
          f.bnd.res[1] = '{K_TX, BYTE_ACK};
          f.bnd.cnt    = 2'd2;
        end
      end
      ID_FIN: begin
        f.to_done    = 1'b1;
        f.bnd.res[0] = '{K_TX, BYTE_ACK};
        f.bnd.res[1] = '{K_DONE, 8'd0};
        f.bnd.cnt    = 2'd2;
      end
      ID_DATA: begin
        if (len == 16'd0) begin
          f.bnd.res[0] = '{K_TX, BYTE_NAK};
          f.bnd.cnt    = 2'd1;
        end else if (sum == 8'd0) begin
          f.set_prev   = 1'b1;
          f.bnd.res[0] = '{K_COMMIT, 8'd0};
          f.bnd.res[1] = '{K_TX, BYTE_ACK};
          f.bnd.cnt    = 2'd2;
        end else begin
          f.bnd.res[0] = '{K_DISCARD, 8'd0};
          f.bnd.res[1] = '{K_TX, BYTE_NAK};
          f.bnd.cnt    = 2'd2;
        end
      end
      default: begin
        f.bnd.res[0] = '{K_TX, BYTE_NAK};
        f.bnd.cnt    = 2'd1;
      end
    endcase
    return f;
  endfunction

  logic        in_full;
  logic        in_kind;
  logic [7:0]  in_byte;

  logic [23:0] window, window_next;
  logic [1:0]  fill, fill_next;
  phase_t      phase, phase_next;
  logic [7:0]  current_pid, current_pid_next;
  logic [7:0]  previous_pid, previous_pid_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] byte_count, byte_count_next;
  logic [7:0]  payload_sum, payload_sum_next;

  logic [16:0] cnt1;
  logic [7:0]  b0, b1, b2, hsum, sum_new;
  logic [15:0] hlen;
  logic        is_data;
  fin_t        fin;

  assign take       = in_full && free;
  assign item_ready = !in_full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item_valid && item_ready) begin
      in_full <= 1'b1;
    end else if (take) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      in_kind <= kind;
      in_byte <= rx_byte;
    end
  end

  assign b0      = window[23:16];
  assign b1      = window[15:8];
  assign b2      = window[7:0];
  assign hsum    = b0 + b1 + b2 + in_byte;
  assign hlen    = {b1, b2};
  assign cnt1    = {1'b0, byte_count} + 17'd1;
  assign sum_new = payload_sum + in_byte;
  assign is_data = (current_pid & ID_MASK) == ID_DATA;

  always_comb begin
    bnd                 = '0;
    fin                 = '0;
    window_next         = window;
    fill_next           = fill;
    phase_next          = phase;
    current_pid_next    = current_pid;
    previous_pid_next   = previous_pid;
    payload_length_next = payload_length;
    byte_count_next     = byte_count;
    payload_sum_next    = payload_sum;

    if (take && phase != PH_DONE) begin
      if (in_kind == KIND_TIMEOUT) begin
        if (phase == PH_LOAD) begin
          if (is_data) begin
            bnd.res[0] = '{K_DISCARD, 8'd0};
            bnd.res[1] = '{K_TX, BYTE_NAK};
            bnd.cnt    = 2'd2;
          end else begin
            bnd.res[0] = '{K_TX, BYTE_NAK};
            bnd.cnt    = 2'd1;
          end
        end
        window_next = '0;
        fill_next   = '0;
        phase_next  = PH_HUNT;
      end else begin
        case (phase)
          PH_HUNT: begin
            if (fill != 2'd3) begin
              window_next = {window[15:0], in_byte};
              fill_next   = fill + 2'd1;
            end else if (hsum == 8'd0 && b0 == previous_pid) begin
              // retransmission: skip its payload
              window_next = '0;
              fill_next   = '0;
              if (hlen == 16'd0) begin
                bnd.res[0] = '{K_TX, BYTE_ACK};
                bnd.cnt    = 2'd1;
              end else begin
                payload_length_next = hlen;
                byte_count_next     = '0;
                phase_next          = PH_SKIP;
              end
            end else if (hsum == 8'd0 && ((b0 & ID_MASK) inside
                         {ID_POLL, ID_BAUD, ID_DATA, ID_FIN})) begin
              window_next         = '0;
              fill_next           = '0;
              current_pid_next    = b0;
              payload_length_next = hlen;
              byte_count_next     = '0;
              payload_sum_next    = '0;
              if (hlen == 16'd0) begin
                fin        = finish(b0, 16'd0, 8'd0, baud_code);
                bnd        = fin.bnd;
                phase_next = fin.to_done ? PH_DONE : PH_HUNT;
                if (fin.set_prev) previous_pid_next = b0;
              end else begin
                phase_next = PH_LOAD;
              end
            end else begin
              // bad header: slide by one byte
              window_next = {window[15:0], in_byte};
              bnd.res[0]  = '{K_TX, BYTE_NAK};
              bnd.cnt     = 2'd1;
            end
          end
          PH_SKIP: begin
            byte_count_next = cnt1[15:0];
            if (cnt1[15:0] >= payload_length) begin
              phase_next = PH_HUNT;
              bnd.res[0] = '{K_TX, BYTE_ACK};
              bnd.cnt    = 2'd1;
            end
          end
          PH_LOAD: begin
            byte_count_next  = cnt1[15:0];
            payload_sum_next = sum_new;
            if (is_data && cnt1 < {1'b0, payload_length}) begin
              bnd.res[0] = '{K_TENT, in_byte};
              bnd.cnt    = 2'd1;
            end
            if (cnt1[15:0] >= payload_length) begin
              fin        = finish(current_pid, payload_length, sum_new, baud_code);
              bnd        = fin.bnd;
              phase_next = fin.to_done ? PH_DONE : PH_HUNT;
              if (fin.set_prev) previous_pid_next = current_pid;
            end
          end
          default: begin
            phase_next = PH_DONE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      fill           <= '0;
      phase          <= PH_HUNT;
      current_pid    <= '0;
      previous_pid   <= PID_INIT;
      payload_length <= '0;
      byte_count     <= '0;
      payload_sum    <= '0;
    end else begin
      window         <= window_next;
      fill           <= fill_next;
      phase          <= phase_next;
      current_pid    <= current_pid_next;
      previous_pid   <= previous_pid_next;
      payload_length <= payload_length_next;
      byte_count     <= byte_count_next;
      payload_sum    <= payload_sum_next;
    end
  end

endmodule

[src/spr_emit.sv]
// ----------------------------------------------------------------------------
// spr_emit
// Result register; sends the bundle of one input beat one result per beat.
// ----------------------------------------------------------------------------
module spr_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  spr_pkg::bundle_t bnd,
  output logic             free,
  output logic             result_valid,
  input  logic             result_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_byte,
  output logic             last
);
  import spr_pkg::*;

  bundle_t    held;
  logic       full;
  logic [1:0] idx;

  assign result_valid = full;
  assign out_kind     = held.res[idx].kind;
  assign out_byte     = held.res[idx].data;
  assign last         = idx == (held.cnt - 2'd1);
  // the next bundle may load in the cycle the final beat leaves
  assign free         = !full || (result_ready && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (take) begin
      full <= bnd.cnt != 2'd0;
      idx  <= '0;
    end else if (full && result_ready) begin
      if (last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= bnd;
    end
  end

endmodule

[src/serial_packet_receiver_ack_nak_top.sv]
// ----------------------------------------------------------------------------
// serial_packet_receiver_ack_nak_top
// Serial packet receiver with ACK/NAK replies, tentative payload and commit.
// ----------------------------------------------------------------------------
// One input beat (received byte or timeout) is taken per cycle into an input
// register unless a held beat cannot move on, and is resolved combinationally
// into up to three results, which the result register hands out one per
// cycle while result_ready is high. An input beat occupies the output for one
// result beat per result (zero to three); the next beat waits in the input
// register while earlier results drain. baud_code is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module serial_packet_receiver_ack_nak_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       item_valid,
  output logic       item_ready,
  input  logic       kind,
  input  logic [7:0] rx_byte,
  output logic       result_valid,
  input  logic       result_ready,
  output logic [2:0] out_kind,
  output logic [7:0] out_byte,
  output logic       last
);
  import spr_pkg::*;

  logic [1:0] baud_code;
  logic       take;
  logic       free;
  bundle_t    bnd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      baud_code <= 2'd0;
    end else if (cfg_valid && cfg_ready) begin
      baud_code <= cfg_data;
    end
  end

  spr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .kind       (kind),
    .rx_byte    (rx_byte),
    .baud_code  (baud_code),
    .free       (free),
    .take       (take),
    .bnd        (bnd)
  );

  spr_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .bnd          (bnd),
    .free         (free),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .last         (last)
  );

endmodule

[src/spr_checker.sv]
// ----------------------------------------------------------------------------
// spr_checker
// Port-level checks of the serial packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
module spr_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic       last
);
  import spr_pkg::*;

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=>
      result_valid && $stable(out_kind) && $stable(out_byte) && $stable(last))
    else $error("stalled result beat changed");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // commit, discard and switch never end a bundle: an ack or nak follows them
  a_not_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && (out_kind == K_COMMIT || out_kind == K_DISCARD || out_kind == K_SWITCH)
      |-> !last)
    else $error("commit, discard or switch ended a bundle");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_kind == K_DONE |-> last)
    else $error("done was not the final result");

  a_switch_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && out_kind == K_SWITCH |-> out_byte != 8'd0 && out_byte[7:2] == 6'd0)
    else $error("switch with a bad baud code");

endmodule

bind serial_packet_receiver_ack_nak_top spr_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .out_kind     (out_kind),
  .out_byte     (out_byte),
  .last         (last)
);

[tb/tb_serial_packet_receiver_ack_nak_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_serial_packet_receiver_ack_nak_top
// Drives line bytes and timeouts into the packet receiver and predicts every
// reply, tentative byte, commit, discard, baud switch and done result from a
// model of the header hunt, skip and payload phases. The directed packets come
// first, then random packets, broken headers and line noise with random
// stalls on both sides. A fin packet closes the run.
// ----------------------------------------------------------------------------
module tb_serial_packet_receiver_ack_nak_top;
  import spr_pkg::*;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       is_last;
  } reply_t;

  class reply_scoreboard;
    logic [23:0] window;
    logic [1:0]  fill;
    phase_t      ph;
    logic [7:0]  cur_pid;
    logic [7:0]  prev_pid;
    logic [15:0] plen;
    logic [15:0] bcount;
    logic [7:0]  psum;
    logic [1:0]  baud;
    reply_t      step[$];
    reply_t      replies_due[$];
    int          errors;

    function new();
      window   = '0;
      fill     = '0;
      ph       = PH_HUNT;
      cur_pid  = '0;
      prev_pid = PID_INIT;
      plen     = '0;
      bcount   = '0;
      psum     = '0;
      baud     = '0;
      errors   = 0;
    endfunction

    function void set_baud(logic [1:0] v);
      baud = v;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    function void push_reply(logic [2:0] k, logic [7:0] d);
      reply_t r;
      r.kind    = k;
      r.data    = d;
      r.is_last = 1'b0;
      step.push_back(r);
    endfunction

    function bit pid_known(logic [7:0] pid);
      logic [7:0] p;
      p = pid & ID_MASK;
      return p == ID_POLL || p == ID_BAUD || p == ID_DATA || p == ID_FIN;
    endfunction

    // whole packet in, act on it
    function void act_on_packet();
      ph = PH_HUNT;
      case (cur_pid & ID_MASK)
        ID_POLL: begin
          prev_pid = cur_pid;
          push_reply(K_TX, BYTE_ACK);
        end
        ID_BAUD: begin
          prev_pid = cur_pid;
          push_reply(K_TX, {6'd0, baud});
          if (baud != 2'd0) push_reply(K_SWITCH, {6'd0, baud});
          push_reply(K_TX, BYTE_ACK);
        end
        ID_FIN: begin
          push_reply(K_TX, BYTE_ACK);
          push_reply(K_DONE, 8'd0);
          ph = PH_DONE;
        end
        ID_DATA: begin
          if (plen == 16'd0) begin
            push_reply(K_TX, BYTE_NAK);
          end else if (psum == 8'd0) begin
            prev_pid = cur_pid;
            push_reply(K_COMMIT, 8'd0);
            push_reply(K_TX, BYTE_ACK);
          end else begin
            push_reply(K_DISCARD, 8'd0);
            push_reply(K_TX, BYTE_NAK);
          end
        end
        default: push_reply(K_TX, BYTE_NAK);
      endcase
    endfunction

    // one accepted input beat
    function void take_beat(logic k, logic [7:0] b);
      logic [7:0]  b0, b1, b2, hsum;
      logic [15:0] len;
      bit          taken;
      step = {};
      if (ph == PH_DONE) return;
      if (k == KIND_TIMEOUT) begin
        if (ph == PH_LOAD) begin
          if ((cur_pid & ID_MASK) == ID_DATA) push_reply(K_DISCARD, 8'd0);
          push_reply(K_TX, BYTE_NAK);
        end
        window = '0;
        fill   = '0;
        ph     = PH_HUNT;
      end else if (ph == PH_HUNT) begin
        if (fill < 2'd3) begin
          window = {window[15:0], b};
          fill   = fill + 2'd1;
        end else begin
          b0    = window[23:16];
          b1    = window[15:8];
          b2    = window[7:0];
          hsum  = b0 + b1 + b2 + b;
          len   = {b1, b2};
          taken = 1'b0;
          if (hsum == 8'd0) begin
            // a repeat of the last good pid wins over the pid check
            if (b0 == prev_pid) begin
              taken  = 1'b1;
              window = '0;
              fill   = '0;
              if (len == 16'd0) begin
                push_reply(K_TX, BYTE_ACK);
              end else begin
                plen   = len;
                bcount = '0;
                ph     = PH_SKIP;
              end
            end else if (pid_known(b0)) begin
              taken   = 1'b1;
              window  = '0;
              fill    = '0;
              cur_pid = b0;
              plen    = len;
              bcount  = '0;
              psum    = '0;
              if (len == 16'd0) act_on_packet();
              else ph = PH_LOAD;
            end
          end
          if (!taken) begin
            window = {window[15:0], b};
            push_reply(K_TX, BYTE_NAK);
          end
        end
      end else if (ph == PH_SKIP) begin
        bcount = bcount + 16'd1;
        if (bcount >= plen) begin
          ph = PH_HUNT;
          push_reply(K_TX, BYTE_ACK);
        end
      end else begin
        // the check byte at the end is never streamed
        if ((cur_pid & ID_MASK) == ID_DATA &&
            ({1'b0, bcount} + 17'd1) < {1'b0, plen})
          push_reply(K_TENT, b);
        bcount = bcount + 16'd1;
        psum   = psum + b;
        if (bcount >= plen) act_on_packet();
      end
      if (step.size() > 0) step[step.size() - 1].is_last = 1'b1;
      foreach (step[i]) replies_due.push_back(step[i]);
    endfunction

    function void check_reply(logic [2:0] k, logic [7:0] d, logic l);
      reply_t e;
      if (replies_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result kind=%0d byte=%02h last=%0b",
                   $realtime, k, d, l);
        return;
      end
      e = replies_due.pop_front();
      if (k !== e.kind || d !== e.data || l !== e.is_last) begin
        errors++;
        if (errors <= 10)
          $display({"%0t: result mismatch exp kind=%0d byte=%02h last=%0b,",
                    " got kind=%0d byte=%02h last=%0b"},
                   $realtime, e.kind, e.data, e.is_last, k, d, l);
      end
    endfunction
  endclass

  localparam int PKT_GOOD    = 0;
  localparam int PKT_BAD_SUM = 1;
  localparam int PKT_CUT     = 2;
  localparam int PKT_BAD_HDR = 3;

  logic       clk;
  logic       rst;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_data;
  logic       item_valid;
  logic       item_ready;
  logic       kind;
  logic [7:0] rx_byte;
  logic       result_valid;
  logic       result_ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       last;

  reply_scoreboard sb = new();
  bit idle_on;
  int beats_sent;

  serial_packet_receiver_ack_nak_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .kind         (kind),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .out_kind     (out_kind),
    .out_byte     (out_byte),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side stalls in bursts
  initial begin
    int stall_left;
    stall_left = 0;
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        stall_left = $urandom_range(1, 7) - 1;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) sb.check_reply(out_kind, out_byte, last);
  end

  // returns just after the accepting edge with valid still high
  task automatic send_beat(input logic k, input logic [7:0] b);
    int gap;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    kind       <= k;
    rx_byte    <= b;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    sb.take_beat(k, b);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    // a beat with no result may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_baud(input logic [1:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_baud(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_timeout();
    send_beat(KIND_TIMEOUT, 8'($urandom));
  endtask

  task automatic send_packet(input logic [7:0] pid, input logic [15:0] len, input int mode);
    logic [7:0] ck, pay_sum, b;
    int cut;
    ck = 8'd0 - pid - len[15:8] - len[7:0];
    if (mode == PKT_BAD_HDR) ck = ck ^ 8'($urandom_range(1, 255));
    send_beat(KIND_BYTE, pid);
    send_beat(KIND_BYTE, len[15:8]);
    send_beat(KIND_BYTE, len[7:0]);
    send_beat(KIND_BYTE, ck);
    if (mode == PKT_BAD_HDR) begin
      send_timeout();
      return;
    end
    cut = int'(len);
    if (mode == PKT_CUT)
      cut = (len == 16'd0) ? 0 : $urandom_range(0, (len > 16'd8) ? 8 : int'(len) - 1);
    pay_sum = 8'd0;
    for (int i = 0; i < cut; i++) begin
      b = 8'($urandom);
      // final byte is the payload check byte
      if (i == int'(len) - 1) begin
        b = 8'd0 - pay_sum;
        if (mode == PKT_BAD_SUM) b = b ^ 8'($urandom_range(1, 255));
      end
      pay_sum = pay_sum + b;
      send_beat(KIND_BYTE, b);
    end
    if (mode == PKT_CUT) send_timeout();
  endtask

  initial begin
    logic [7:0]  known_pids [3];
    logic [7:0]  pid;
    logic [15:0] len;
    int          sel;
    known_pids = '{ID_POLL, ID_BAUD, ID_DATA};
    idle_on    = 1'b1;
    beats_sent = 0;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_data   = 2'd0;
    item_valid = 1'b0;
    kind       = KIND_BYTE;
    rx_byte    = 8'd0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed packets
    write_baud(2'd0);
    send_packet(PID_INIT, 16'd0, PKT_GOOD);               // matches reset pid: repeat
    send_packet(ID_POLL, 16'd0, PKT_GOOD);
    send_packet(ID_POLL, 16'd2, PKT_GOOD);                // repeat, payload skipped
    send_packet(ID_POLL, 16'd3, PKT_CUT);                 // timeout while skipping
    send_packet(ID_POLL | 8'd1, 16'd2, PKT_CUT);          // timeout in non-data payload
    send_packet(ID_DATA | 8'd1, 16'd1, PKT_GOOD);
    send_packet(ID_DATA, 16'd0, PKT_GOOD);                // empty data
    send_packet(ID_DATA, 16'd4, PKT_BAD_SUM);
    send_packet(ID_DATA, 16'hFFFF, PKT_CUT);
    send_packet(ID_BAUD | 8'd1, 16'd0, PKT_GOOD);         // code zero, no switch
    send_packet(8'h36, 16'd0, PKT_GOOD);                  // unknown pid
    send_timeout();
    send_packet(ID_POLL, 16'd1, PKT_BAD_HDR);
    send_beat(KIND_BYTE, 8'hFF);
    send_beat(KIND_BYTE, 8'h00);
    send_timeout();
    write_baud(2'd3);
    send_packet(ID_BAUD, 16'd1, PKT_GOOD);
    send_packet(ID_DATA | 8'd1, 16'h0100, PKT_CUT);

    // random packets
    while (beats_sent < 160) begin
      idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 11) == 0) write_baud(2'($urandom_range(0, 3)));
      pid = known_pids[$urandom_range(0, 2)] | 8'($urandom_range(0, 1));
      len = 16'($urandom_range(0, 6));
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_packet(pid, len, PKT_GOOD);
      end else if (sel < 72) begin
        send_packet(ID_DATA | 8'($urandom_range(0, 1)), len, PKT_BAD_SUM);
      end else if (sel < 82) begin
        send_packet(pid, len, PKT_CUT);
      end else if (sel < 87) begin
        send_packet(pid, 16'($urandom), PKT_CUT);
      end else if (sel < 92) begin
        send_packet(pid, len, PKT_BAD_HDR);
      end else if (sel < 96) begin
        pid = 8'($urandom);
        if ((pid & ID_MASK) == ID_FIN) pid = pid ^ 8'h80;
        send_packet(pid, len, PKT_GOOD);
        send_timeout();
      end else begin
        repeat ($urandom_range(1, 6)) send_beat(KIND_BYTE, 8'($urandom));
        send_timeout();
      end
    end

    // closing stretch without idling, fin then ignored beats
    idle_on = 1'b0;
    send_packet(ID_DATA, 16'd3, PKT_GOOD);
    send_packet(ID_FIN | 8'($urandom_range(0, 1)), 16'($urandom_range(0, 3)), PKT_GOOD);
    send_beat(KIND_BYTE, 8'($urandom));
    send_timeout();
    drain();
    repeat (10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[files.f]
src/spr_pkg.sv
src/spr_core.sv
src/spr_emit.sv
src/serial_packet_receiver_ack_nak_top.sv
src/spr_checker.sv
tb/tb_serial_packet_receiver_ack_nak_top.sv
